>>> design/bf3_pkg.sv
// Shared types, constants and the divide-by-window-size function of the 3x3 box filter.
// Depends on nothing; imported by the top level box_filter_3x3_rgb.
`default_nettype none

package bf3_pkg;

    localparam int PIX_W       = 16;      // one color component
    localparam int CH_N        = 3;       // red, green, blue
    localparam int COL_W       = 18;      // sum of up to three components
    localparam int SUM_W       = 20;      // sum of up to nine components
    localparam int CFG_W       = 11;      // frame_side register
    localparam int MIN_SIDE    = 2;
    localparam int SIDE_RESET  = 1024;
    localparam int RECIP_SHIFT = 23;
    localparam int MUL_W       = 22;

    // Reciprocals scaled by 2**23, rounded up; exact for sums below 2**20.
    localparam logic [MUL_W-1:0] RECIP_4 = 22'd2097152;
    localparam logic [MUL_W-1:0] RECIP_6 = 22'd1398102;
    localparam logic [MUL_W-1:0] RECIP_9 = 22'd932068;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef logic [CH_N-1:0][PIX_W-1:0] t_rgb;
    typedef logic [CH_N-1:0][COL_W-1:0] t_col;
    typedef logic [CH_N-1:0][SUM_W-1:0] t_sum;

    typedef enum logic [1:0] {
        DIV4 = 2'b00,
        DIV6 = 2'b01,
        DIV9 = 2'b10
    } t_div;

    // Position flags of an item, worked out when it is accepted.
    typedef struct packed {
        logic tick;      // flush tick rather than pixel
        logic sel;       // line store bank that holds the older of the two stored rows
        logic row_ge1;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic col_last;  // rightmost column
        logic cap0;      // first pixel of the bottom row
        logic fl_left;   // flush column has a left neighbor
        logic fl_right;  // flush column has a right neighbor
        logic fl_last;   // last flush column
    } t_s1_ctl;

    typedef struct packed {
        t_sum sum;
        t_div div;
        logic lof;
    } t_res;

    function automatic logic [PIX_W-1:0] mean_div(input logic [SUM_W-1:0] sum,
                                                  input t_div div);
        logic [MUL_W-1:0]       recip;
        logic [SUM_W+MUL_W-1:0] prod;
        case (div)
            DIV4:    recip = RECIP_4;
            DIV6:    recip = RECIP_6;
            DIV9:    recip = RECIP_9;
            default: recip = RECIP_4;
        endcase
        prod = {{MUL_W{1'b0}}, sum} * {{SUM_W{1'b0}}, recip};
        return prod[RECIP_SHIFT +: PIX_W];
    endfunction

endpackage

`default_nettype wire

>>> design/box_filter_3x3_rgb.sv
// 3x3 box filter over a square RGB frame: two line store banks, window sums, mean.
// Depends on bf3_pkg and bf3_ram.
//
// Input channel (i_valid / o_stall): pixels of the frame in raster order (i_kind = pixel),
// then flush ticks (i_kind = flush) that bring out the bottom row, one output per tick.
// Pixels sent during the flush and ticks sent outside it are taken and dropped.
// Output channel (o_valid / i_stall): the truncated mean of the clipped 3x3 window, in
// raster order. The output for a pixel appears once its lower-right neighbor has arrived;
// the last pixel of each row from the second row on also gives the rightmost output of
// the row above, so that item has two results.
// One item is accepted per cycle while the receiver does not stall; an item with two results
// holds up the input, as the divide stage hands out one result per cycle when not stalled.
// A write of frame_side restarts the frame; it is clamped to 2..MAX_SIDE. Reset sets
// frame_side to 1024 (or MAX_SIDE if smaller), empties the pipeline and starts a new frame;
// the line store is not cleared. While the receiver stalls, the output holds and the
// pipeline fills, after which o_stall rises.
`default_nettype none

module box_filter_3x3_rgb
    import bf3_pkg::*;
#(
    parameter int MAX_SIDE = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_kind,
    input  wire logic [PIX_W-1:0]   i_in_red,
    input  wire logic [PIX_W-1:0]   i_in_green,
    input  wire logic [PIX_W-1:0]   i_in_blue,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic      [PIX_W-1:0]   o_out_red,
    output logic      [PIX_W-1:0]   o_out_green,
    output logic      [PIX_W-1:0]   o_out_blue,
    output logic                    o_last_of_item,
    output logic                    o_last_of_frame
);

    localparam int CW       = $clog2(MAX_SIDE);
    localparam int RAM_W    = CH_N * PIX_W;
    localparam int SIDE_RST = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
    localparam logic [CW-1:0] LAST_RST = CW'(SIDE_RST - 1);

    // Frame position and flush state.
    logic [CW-1:0] r_last, n_last;
    logic [CW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_fcol, n_fcol;
    logic          r_flushing, n_flushing;
    logic [31:0]   cfg_side;

    // Stage 1: accepted item, line store data arriving.
    logic          r_s1_valid;
    t_s1_ctl       r_s1_ctl, n_s1_ctl;
    t_rgb          r_s1_pix;
    t_col          r_wc_prev, r_wc_old;
    t_col          r_fw_a, r_fw_b;

    // Stage 2: window sums waiting for the divide.
    logic          r_s2_valid;
    logic          r_s2_two;
    logic          r_s2_ptr;
    t_res          r_s2_slot0, r_s2_slot1;

    // Output register.
    logic          r_out_valid;
    t_rgb          r_out_pix;
    logic          r_out_loi;
    logic          r_out_lof;

    logic          accept, take_pix, take_tick, take_any;
    logic          s1_ready, s1_adv, s1_fire, s1_no_res, s1_load;
    logic          s2_ready, s2_emit, s2_done, s2_last;
    logic          out_ready;
    logic          ram_we0, ram_we1;
    logic [CW-1:0] ram_raddr;
    logic [RAM_W-1:0] ram0_q, ram1_q;
    t_rgb          in_pix, s1_older, s1_newer;
    t_col          s1_pcol, s1_cap, s1_fcur;
    t_sum          s1_sum_a, s1_sum_b, s1_sum_t;
    t_res          s1_res0, s1_res1, s2_cur;

    // ---------------------------------------------------------------- input side
    assign in_pix    = {i_in_blue, i_in_green, i_in_red};
    assign o_stall   = !s1_ready;
    assign accept    = i_valid && !o_stall;
    assign take_pix  = accept && (i_kind == KIND_PIXEL) && !r_flushing;
    assign take_tick = accept && (i_kind == KIND_FLUSH) && r_flushing;
    assign take_any  = take_pix || take_tick;

    always_comb begin
        cfg_side = 32'(i_cfg_data);
        if (cfg_side < 32'(MIN_SIDE)) begin
            cfg_side = 32'(MIN_SIDE);
        end else if (cfg_side > 32'(MAX_SIDE)) begin
            cfg_side = 32'(MAX_SIDE);
        end
    end

    always_comb begin
        n_last     = r_last;
        n_row      = r_row;
        n_col      = r_col;
        n_fcol     = r_fcol;
        n_flushing = r_flushing;
        if (i_cfg_we) begin
            n_last     = CW'(cfg_side - 32'd1);
            n_row      = '0;
            n_col      = '0;
            n_fcol     = '0;
            n_flushing = 1'b0;
        end else if (take_pix) begin
            if (r_col == r_last) begin
                n_col = '0;
                if (r_row == r_last) begin
                    n_row      = '0;
                    n_flushing = 1'b1;
                    n_fcol     = '0;
                end else begin
                    n_row = r_row + CW'(1);
                end
            end else begin
                n_col = r_col + CW'(1);
            end
        end else if (take_tick) begin
            if (r_fcol == r_last) begin
                n_fcol     = '0;
                n_flushing = 1'b0;
            end else begin
                n_fcol = r_fcol + CW'(1);
            end
        end
    end

    always_comb begin
        n_s1_ctl.tick     = (i_kind == KIND_FLUSH);
        // Row n-2 has the parity of n, and n = last + 1.
        n_s1_ctl.sel      = (i_kind == KIND_FLUSH) ? !r_last[0] : r_row[0];
        n_s1_ctl.row_ge1  = (r_row != '0);
        n_s1_ctl.row_ge2  = (r_row > CW'(1));
        n_s1_ctl.col_ge1  = (r_col != '0);
        n_s1_ctl.col_ge2  = (r_col > CW'(1));
        n_s1_ctl.col_last = (r_col == r_last);
        n_s1_ctl.cap0     = (r_row == r_last) && (r_col == '0);
        n_s1_ctl.fl_left  = (r_fcol != '0);
        n_s1_ctl.fl_right = (r_fcol != r_last);
        n_s1_ctl.fl_last  = (r_fcol == r_last);
    end

    // Bank b holds the rows of parity b. A pixel reads the two rows above it and
    // overwrites the older one; a flush tick reads the column to the right.
    assign ram_we0   = take_pix && !r_row[0];
    assign ram_we1   = take_pix && r_row[0];
    assign ram_raddr = take_tick ? (r_fcol + CW'(1)) : r_col;

    bf3_ram #(
        .DATA_W (RAM_W),
        .DEPTH  (MAX_SIDE)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (ram_we0),
        .i_waddr (r_col),
        .i_wdata (in_pix),
        .i_re    (take_any),
        .i_raddr (ram_raddr),
        .o_rdata (ram0_q)
    );

    bf3_ram #(
        .DATA_W (RAM_W),
        .DEPTH  (MAX_SIDE)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (ram_we1),
        .i_waddr (r_col),
        .i_wdata (in_pix),
        .i_re    (take_any),
        .i_raddr (ram_raddr),
        .o_rdata (ram1_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= LAST_RST;
            r_row      <= '0;
            r_col      <= '0;
            r_fcol     <= '0;
            r_flushing <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_last     <= n_last;
            r_row      <= n_row;
            r_col      <= n_col;
            r_fcol     <= n_fcol;
            r_flushing <= n_flushing;
            if (s1_ready) begin
                r_s1_valid <= take_any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_any) begin
            r_s1_ctl <= n_s1_ctl;
            r_s1_pix <= in_pix;
        end
    end

    // ---------------------------------------------------------------- stage 1
    assign s1_older  = r_s1_ctl.sel ? t_rgb'(ram1_q) : t_rgb'(ram0_q);
    assign s1_newer  = r_s1_ctl.sel ? t_rgb'(ram0_q) : t_rgb'(ram1_q);
    assign s1_no_res = !r_s1_ctl.tick && !(r_s1_ctl.row_ge1 && r_s1_ctl.col_ge1);
    assign s1_adv    = s1_no_res || s2_ready;
    assign s1_ready  = !r_s1_valid || s1_adv;
    assign s1_fire   = r_s1_valid && s1_adv;
    assign s1_load   = s1_fire && !s1_no_res;

    always_comb begin
        for (int ch = 0; ch < CH_N; ch++) begin
            s1_cap[ch]   = (r_s1_ctl.row_ge1 ? COL_W'(s1_newer[ch]) : '0)
                         + COL_W'(r_s1_pix[ch]);
            s1_pcol[ch]  = s1_cap[ch]
                         + (r_s1_ctl.row_ge2 ? COL_W'(s1_older[ch]) : '0);
            s1_fcur[ch]  = r_s1_ctl.fl_right
                         ? COL_W'(s1_older[ch]) + COL_W'(s1_newer[ch]) : '0;
            s1_sum_b[ch] = SUM_W'(r_wc_prev[ch]) + SUM_W'(s1_pcol[ch]);
            s1_sum_a[ch] = s1_sum_b[ch]
                         + (r_s1_ctl.col_ge2 ? SUM_W'(r_wc_old[ch]) : '0);
            s1_sum_t[ch] = SUM_W'(r_fw_b[ch]) + SUM_W'(s1_fcur[ch])
                         + (r_s1_ctl.fl_left ? SUM_W'(r_fw_a[ch]) : '0);
        end
    end

    always_comb begin
        s1_res0.lof = r_s1_ctl.tick && r_s1_ctl.fl_last;
        if (r_s1_ctl.tick) begin
            s1_res0.sum = s1_sum_t;
            s1_res0.div = (r_s1_ctl.fl_left && r_s1_ctl.fl_right) ? DIV6 : DIV4;
        end else begin
            s1_res0.sum = s1_sum_a;
            if (r_s1_ctl.row_ge2 && r_s1_ctl.col_ge2) begin
                s1_res0.div = DIV9;
            end else if (r_s1_ctl.row_ge2 || r_s1_ctl.col_ge2) begin
                s1_res0.div = DIV6;
            end else begin
                s1_res0.div = DIV4;
            end
        end
        s1_res1.sum = s1_sum_b;
        s1_res1.div = r_s1_ctl.row_ge2 ? DIV6 : DIV4;
        s1_res1.lof = 1'b0;
    end

    // Pixel window keeps per-channel column sums of the two columns to the left.
    // The flush window holds two-row column sums of the bottom two rows; its first
    // column is captured as the bottom row's first pixel goes by.
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            if (r_s1_ctl.tick) begin
                r_fw_a <= r_fw_b;
                r_fw_b <= s1_fcur;
            end else begin
                r_wc_old  <= r_wc_prev;
                r_wc_prev <= s1_pcol;
                if (r_s1_ctl.cap0) begin
                    r_fw_b <= s1_cap;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stage 2
    assign s2_cur   = r_s2_ptr ? r_s2_slot1 : r_s2_slot0;
    assign s2_last  = r_s2_ptr || !r_s2_two;
    assign s2_emit  = r_s2_valid && out_ready;
    assign s2_done  = s2_emit && s2_last;
    assign s2_ready = !r_s2_valid || s2_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s2_ptr   <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= s1_load;
            r_s2_ptr   <= 1'b0;
        end else if (s2_emit) begin
            r_s2_ptr <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s2_slot0 <= s1_res0;
            r_s2_slot1 <= s1_res1;
            r_s2_two   <= !r_s1_ctl.tick && r_s1_ctl.col_last;
        end
    end

    // ---------------------------------------------------------------- output
    assign out_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_emit) begin
            for (int ch = 0; ch < CH_N; ch++) begin
                r_out_pix[ch] <= mean_div(s2_cur.sum[ch], s2_cur.div);
            end
            r_out_loi <= s2_last;
            r_out_lof <= s2_cur.lof;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_red       = r_out_pix[0];
    assign o_out_green     = r_out_pix[1];
    assign o_out_blue      = r_out_pix[2];
    assign o_last_of_item  = r_out_loi;
    assign o_last_of_frame = r_out_lof;

`ifndef NO_ASSERTIONS
    a_ptr_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_ptr |-> (r_s2_valid && r_s2_two))
        else $error("second result selected without a two-result item");

    a_taken_reaches_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_any |=> r_s1_valid)
        else $error("processed item did not enter stage 1");

    a_flush_counters_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flushing |-> ((r_row == '0) && (r_col == '0)))
        else $error("frame position moved during flush");

    a_frame_end_is_item_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_lof) |-> r_out_loi)
        else $error("frame end flagged on a result that is not the item's last");
`endif

endmodule

`default_nettype wire

>>> design/bf3_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing; used for the line store banks of box_filter_3x3_rgb.
`default_nettype none

module bf3_ram #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [DATA_W-1:0]          i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [DATA_W-1:0]          o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> test/box_filter_3x3_rgb_test.sv
// Testbench of box_filter_3x3_rgb: directed small frames, one pass at the largest side and
// random frames with flush ticks, noise and restarts, all checked against a local predictor.
// Depends on bf3_pkg and the box_filter_3x3_rgb RTL.
module box_filter_3x3_rgb_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bf3_pkg::*;

    localparam int MAX_SIDE      = 1024;
    localparam int RANDOM_ITEMS  = 500;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef logic [CH_N*PIX_W-1:0] t_pixel;   // blue, green, red from the top down

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last_item;
        logic             last_frame;
    } t_mean;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_kind = KIND_PIXEL;
    logic [PIX_W-1:0]   i_in_red = '0;
    logic [PIX_W-1:0]   i_in_green = '0;
    logic [PIX_W-1:0]   i_in_blue = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [PIX_W-1:0]   o_out_red;
    logic [PIX_W-1:0]   o_out_green;
    logic [PIX_W-1:0]   o_out_blue;
    logic               o_last_of_item;
    logic               o_last_of_frame;

    // Predictor state.
    t_pixel      line_mem [0:2*MAX_SIDE-1];
    t_pixel      win_cols [0:5];
    int unsigned side_reg = SIDE_RESET;
    int unsigned cur_row = 0;
    int unsigned cur_col = 0;
    int unsigned flush_left = 0;
    int unsigned acc_red, acc_green, acc_blue, acc_n;
    t_mean       means_due [$];

    int    errors = 0;
    int    effective_items = 0;
    int    stall_left = 0;
    int    idle_cycles = 0;
    int    gap_odds = 0;
    int    stall_odds = 0;
    bit    quiet = 1'b0;
    t_mean want;

    box_filter_3x3_rgb #(
        .MAX_SIDE(MAX_SIDE)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_kind(i_kind),
        .i_in_red(i_in_red),
        .i_in_green(i_in_green),
        .i_in_blue(i_in_blue),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_out_red(o_out_red),
        .o_out_green(o_out_green),
        .o_out_blue(o_out_blue),
        .o_last_of_item(o_last_of_item),
        .o_last_of_frame(o_last_of_frame)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned side_now();
        if (side_reg < MIN_SIDE) return MIN_SIDE;
        if (side_reg > MAX_SIDE) return MAX_SIDE;
        return side_reg;
    endfunction

    // Rows alternate between the two banks of the line store.
    function automatic int unsigned slot(input int unsigned row, input int unsigned col);
        return (row % 2) * MAX_SIDE + (col % MAX_SIDE);
    endfunction

    task automatic add_px(input t_pixel px);
        acc_red   += 32'(px[PIX_W-1:0]);
        acc_green += 32'(px[2*PIX_W-1:PIX_W]);
        acc_blue  += 32'(px[3*PIX_W-1:2*PIX_W]);
        acc_n++;
    endtask

    task automatic push_mean(input bit last_item, input bit last_frame);
        t_mean m;
        m.red        = PIX_W'(acc_red / acc_n);
        m.green      = PIX_W'(acc_green / acc_n);
        m.blue       = PIX_W'(acc_blue / acc_n);
        m.last_item  = last_item;
        m.last_frame = last_frame;
        means_due.push_back(m);
        acc_red   = 0;
        acc_green = 0;
        acc_blue  = 0;
        acc_n     = 0;
    endtask

    task automatic blur_step(input logic kind, input logic [PIX_W-1:0] red,
                             input logic [PIX_W-1:0] green, input logic [PIX_W-1:0] blue);
        int unsigned n, r, c, k, kc, rr, first;
        t_pixel      column [0:2];
        n = side_now();
        if (kind == KIND_FLUSH) begin
            if (flush_left != 0 && flush_left <= n) begin
                // A flush tick brings out one column of the bottom row from the stored rows.
                k  = n - flush_left;
                kc = (k >= 1) ? k - 1 : 0;
                while (kc <= k + 1 && kc < n) begin
                    add_px(line_mem[slot(n - 2, kc)]);
                    add_px(line_mem[slot(n - 1, kc)]);
                    kc++;
                end
                push_mean(1'b1, k == n - 1);
                flush_left--;
                effective_items++;
            end
        end else if (flush_left == 0) begin
            r = cur_row;
            c = cur_col;
            if (r >= n || c >= n) begin
                r = 0;
                c = 0;
            end
            column[0] = (r >= 2) ? line_mem[slot(r, c)] : '0;
            column[1] = (r >= 1) ? line_mem[slot(r + 1, c)] : '0;
            column[2] = {blue, green, red};
            line_mem[slot(r, c)] = column[2];
            if (r >= 1) begin
                first = (r >= 2) ? 0 : 1;
                if (c >= 1) begin
                    for (rr = first; rr < 3; rr++) begin
                        if (c >= 2) add_px(win_cols[rr]);
                        add_px(win_cols[3 + rr]);
                        add_px(column[rr]);
                    end
                    push_mean(c != n - 1, 1'b0);
                end
                // The last pixel of a row also finishes the rightmost output of the row above.
                if (c == n - 1) begin
                    for (rr = first; rr < 3; rr++) begin
                        add_px(win_cols[3 + rr]);
                        add_px(column[rr]);
                    end
                    push_mean(1'b1, 1'b0);
                end
            end
            for (rr = 0; rr < 3; rr++) begin
                win_cols[rr]     = win_cols[3 + rr];
                win_cols[3 + rr] = column[rr];
            end
            c++;
            if (c >= n) begin
                c = 0;
                r++;
                if (r >= n) begin
                    r = 0;
                    flush_left = n;
                end
            end
            cur_row = r;
            cur_col = c;
            effective_items++;
        end
    endtask

    // ---------------------------------------------------------------- drivers

    function automatic logic [PIX_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 3;
            2: return 8;
            default: return 20;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_side();
        case ($urandom_range(0, 9))
            0: return CFG_W'(0);
            1: return CFG_W'(1);
            2, 3: return CFG_W'($urandom_range(7, 16));
            default: return CFG_W'($urandom_range(2, 6));
        endcase
    endfunction

    task automatic send_item(input logic kind, input logic [PIX_W-1:0] red,
                             input logic [PIX_W-1:0] green, input logic [PIX_W-1:0] blue);
        int gap;
        if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            gap = $urandom_range(1, 17);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_in_red   <= red;
        i_in_green <= green;
        i_in_blue  <= blue;
        do @(posedge i_clk); while (o_stall);
        blur_step(kind, red, green, blue);
    endtask

    task automatic send_pixel();
        send_item(KIND_PIXEL, rand_chan(), rand_chan(), rand_chan());
    endtask

    task automatic send_tick();
        send_item(KIND_FLUSH, rand_chan(), rand_chan(), rand_chan());
    endtask

    // Stop sending, wait for every expected mean, then let the pipeline run empty.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (means_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_side(input logic [CFG_W-1:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        side_reg   = 32'(value);
        cur_row    = 0;
        cur_col    = 0;
        flush_left = 0;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (!quiet && stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (!quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left <= $urandom_range(0, 16);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string what, input logic [PIX_W-1:0] want_v,
                               input logic [PIX_W-1:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            $display("%0t: %s expected %h, actual %h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (means_due.size() == 0) begin
                errors++;
                $display("%0t: result expected none, actual %h %h %h", $time,
                         o_out_red, o_out_green, o_out_blue);
            end else begin
                want = means_due.pop_front();
                check_field("red", want.red, o_out_red);
                check_field("green", want.green, o_out_green);
                check_field("blue", want.blue, o_out_blue);
                check_field("last_of_item", PIX_W'(want.last_item), PIX_W'(o_last_of_item));
                check_field("last_of_frame", PIX_W'(want.last_frame),
                            PIX_W'(o_last_of_frame));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- tests

    // A few pixels at the reset side; the next side write must throw them away.
    task automatic test_restart_mid_frame();
        repeat (6) send_pixel();
    endtask

    // Side 1 acts as 2: every output is a corner, and one pixel gives two results.
    task automatic test_tiny_frame();
        write_side(11'd1);
        send_tick();
        send_item(KIND_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(KIND_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(KIND_PIXEL, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_item(KIND_PIXEL, 16'h0000, 16'hFFFF, 16'h8001);
        send_tick();
        send_pixel();
        send_tick();
        send_tick();
    endtask

    // Side 3 has corners, edges and one interior position.
    task automatic test_three_frame();
        int i;
        write_side(11'd3);
        for (i = 0; i < 9; i++) begin
            send_item(KIND_PIXEL, (i % 2 == 1) ? 16'hFFFF : 16'h0000,
                      (i % 3 == 0) ? 16'hFFFF : 16'h0000, PIX_W'(16'hFFFF - i));
        end
        repeat (3) send_tick();
    endtask

    // All ones in the register clamp to the largest side; the row must wrap at 1024.
    task automatic test_largest_side();
        int i;
        gap_odds   = 6;
        stall_odds = 6;
        write_side(11'h7FF);
        for (i = 0; i < MAX_SIDE + 2; i++) begin
            if (i == 500) send_tick();
            send_pixel();
        end
    endtask

    task automatic test_random_frames();
        int target, n, cut, i;
        bit restart;
        target  = effective_items + RANDOM_ITEMS;
        restart = 1'b1;
        while (effective_items < target) begin
            gap_odds   = pick_odds();
            stall_odds = pick_odds();
            if (restart || $urandom_range(0, 2) == 0) write_side(pick_side());
            else if ($urandom_range(0, 7) == 0) settle();
            n       = side_now();
            cut     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n * n - 1) : n * n;
            restart = cut < n * n;
            for (i = 0; i < cut; i++) begin
                if ($urandom_range(0, 19) == 0) send_tick();
                send_pixel();
                if (effective_items + 120 >= target) quiet = 1'b1;
            end
            if (!restart) begin
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(0, 9) == 0) send_pixel();
                    send_tick();
                end
                if ($urandom_range(0, 4) == 0) send_tick();
            end
        end
    endtask

    initial begin
        int i;
        for (i = 0; i < 6; i++) win_cols[i] = '0;
        acc_red   = 0;
        acc_green = 0;
        acc_blue  = 0;
        acc_n     = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_restart_mid_frame();
        test_tiny_frame();
        test_three_frame();
        test_largest_side();
        test_random_frames();

        quiet = 1'b1;
        settle();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
